// File: sv/svcm_pkg.sv
// Shared types and constants for the servo speed calibration map.
// Field widths, serial unit sizes, item kind codes and the sequencer state type.
// No dependencies.
`default_nettype none

package svcm_pkg;

   localparam int KIND_W  = 2;
   localparam int IDX_W   = 4;
   localparam int SPD_W   = 16;
   localparam int OFS_W   = 9;
   localparam int GAIN_W  = 16;
   localparam int PULSE_W = 11;

   localparam int GAIN_FRAC = 8;
   localparam int MAG_W     = 10;
   localparam int SUM_W     = 13;

   localparam int MUL_A_W = 9;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int DIV_Q_W = 10;
   localparam int DIV_D_W = 16;
   localparam int DIV_N_W = MUL_P_W;

   localparam int DEF_ENTRIES   = 11;
   localparam int DEF_CENTER_US = 1500;
   localparam int DEF_LIMIT_US  = 200;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SPEED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_INTERP_GO,
      ST_INTERP_MUL,
      ST_INTERP_DIV,
      ST_SCALE_GO,
      ST_SCALE_MUL
   } state_type;

endpackage

`default_nettype wire

// File: sv/svcm_table.sv
// Calibration table memory: one write port, one registered read port.
// Each word holds an entry's speed and pulse offset. Uses svcm_pkg.
`default_nettype none

module svcm_table #(
   parameter  int ENTRIES = svcm_pkg::DEF_ENTRIES,
   localparam int AW      = $clog2(ENTRIES)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [svcm_pkg::SPD_W-1:0] wr_speed,
   input  logic [svcm_pkg::OFS_W-1:0] wr_offset,
   input  logic [AW-1:0]              rd_addr,
   output logic [svcm_pkg::SPD_W-1:0] rd_speed,
   output logic [svcm_pkg::OFS_W-1:0] rd_offset
);
   import svcm_pkg::*;

   logic [SPD_W+OFS_W-1:0] mem [ENTRIES];
   logic [SPD_W+OFS_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_speed, wr_offset};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_speed  = rd_ff[SPD_W+OFS_W-1:OFS_W];
   assign rd_offset = rd_ff[OFS_W-1:0];

endmodule

`default_nettype wire

// File: sv/svcm_mul.sv
// Bit-serial unsigned multiplier: one bit of the short operand per cycle, MSB first.
// Shared by interpolation and gain scaling. Uses svcm_pkg.
`default_nettype none

module svcm_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [svcm_pkg::MUL_A_W-1:0] a,
   input  logic [svcm_pkg::MUL_B_W-1:0] b,
   output logic [svcm_pkg::MUL_P_W-1:0] prod,
   output logic                         done
);
   import svcm_pkg::*;

   localparam int CW = $clog2(MUL_A_W + 1);

   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [MUL_P_W-1:0] acc_ff, acc_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         b_in   = b;
         acc_in = '0;
         cnt_in = CW'(MUL_A_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = {acc_ff[MUL_P_W-2:0], 1'b0}
                + (a_ff[MUL_A_W-1] ? {{MUL_A_W{1'b0}}, b_ff} : {MUL_P_W{1'b0}});
         a_in   = {a_ff[MUL_A_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: sv/svcm_div.sv
// Restoring serial divider: one quotient bit per cycle.
// The caller guarantees the quotient fits DIV_Q_W bits. Uses svcm_pkg.
`default_nettype none

module svcm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [svcm_pkg::DIV_N_W-1:0] num,
   input  logic [svcm_pkg::DIV_D_W-1:0] den,
   output logic [svcm_pkg::DIV_Q_W-1:0] quo,
   output logic                         done
);
   import svcm_pkg::*;

   localparam int CW = $clog2(DIV_Q_W + 1);

   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] den_ff, den_in;
   logic [DIV_Q_W-1:0] q_ff, q_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   shifted;
   logic [DIV_D_W:0]   diff;
   logic               ge;

   assign shifted = {rem_ff, q_ff[DIV_Q_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = DIV_D_W'(num[DIV_N_W-1:DIV_Q_W]);
         q_in   = num[DIV_Q_W-1:0];
         den_in = den;
         cnt_in = CW'(DIV_Q_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
         q_in   = {q_ff[DIV_Q_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign quo  = q_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: sv/servo_speed_calibration_map_unit.sv
// Servo speed calibration map: sequencer, search and scaling datapath.
// Instantiates svcm_table, svcm_mul and svcm_div; uses svcm_pkg.
//
// Command channel: a word is taken when start is high and busy is low.
// Load words write one table entry in that cycle if the index is below
// ENTRIES and give no result; busy stays low, so a load may follow every
// cycle. Speed and direct words raise busy and give one result word on
// rsp_pulse_us / rsp_clamped, shown for one cycle with rsp_strobe. busy is
// low again in that strobe cycle. A direct word goes straight to the serial
// multiply by the gain. A speed word scans the table one entry per cycle
// through the memory read port until an entry's speed exceeds the request
// or the last entry is read; at either end it takes that entry's offset, else
// it interpolates (serial multiply, serial divide) and then does the serial
// multiply by the gain. The gain register is written through csr_wr_en /
// csr_wr_data; the user must write it only while idle; the block does not
// enforce this. Reset clears the sequencer, sets the gain to 1.0 and the
// current offset to zero; table contents are unknown until loaded. The
// receiver cannot stall: each result is valid only in its strobe cycle.
`default_nettype none

module servo_speed_calibration_map_unit #(
   parameter int ENTRIES   = svcm_pkg::DEF_ENTRIES,
   parameter int CENTER_US = svcm_pkg::DEF_CENTER_US,
   parameter int LIMIT_US  = svcm_pkg::DEF_LIMIT_US
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [svcm_pkg::KIND_W-1:0]  req_kind,
   input  logic [svcm_pkg::IDX_W-1:0]   req_entry_index,
   input  logic [svcm_pkg::SPD_W-1:0]   req_table_speed,
   input  logic [svcm_pkg::OFS_W-1:0]   req_table_offset,
   input  logic [svcm_pkg::SPD_W-1:0]   req_speed_request,
   input  logic [svcm_pkg::OFS_W-1:0]   req_direct_offset,
   output logic                         rsp_strobe,
   output logic [svcm_pkg::PULSE_W-1:0] rsp_pulse_us,
   output logic                         rsp_clamped,
   input  logic                         csr_wr_en,
   input  logic [svcm_pkg::GAIN_W-1:0]  csr_wr_data
);
   import svcm_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam logic OUT_FITS = (CENTER_US + LIMIT_US) < (2 ** PULSE_W);

   state_type state_ff, state_in;

   logic [GAIN_W-1:0]  gain_ff;
   logic [SPD_W-1:0]   req_ff;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [SPD_W-1:0]   prev_spd_ff;
   logic [OFS_W-1:0]   prev_ofs_ff;
   logic [OFS_W-1:0]   o0_ff;
   logic               dneg_ff;
   logic [MUL_A_W-1:0] dmag_ff;
   logic [MUL_B_W-1:0] r_ff;
   logic [DIV_D_W-1:0] den_ff;
   logic [OFS_W-1:0]   ofs_ff, ofs_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [PULSE_W-1:0] rsp_pulse_ff;
   logic               rsp_clamped_ff;

   logic accept;
   logic tbl_we;
   logic ld_req, ld_prev, ld_interp, ld_ofs, ld_rsp;
   logic mul_start, div_start;
   logic mul_done, div_done;

   logic [SPD_W-1:0]   rd_speed;
   logic [OFS_W-1:0]   rd_offset;
   logic               hit, first, last;
   logic [SPD_W:0]     r_full, den_full;
   logic [OFS_W:0]     d_full, d_abs;
   logic [OFS_W-1:0]   omag;
   logic [GAIN_W-1:0]  gmag;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_prod;
   logic [DIV_Q_W-1:0] div_q;
   logic [DIV_Q_W-1:0] q_signed;
   logic [OFS_W:0]     interp_sum;
   logic [MUL_P_W-GAIN_FRAC-1:0] smag;
   logic               sat, sneg;
   logic [MAG_W-1:0]   cmag;
   logic [SUM_W-1:0]   scaled, pulse_sum;

   assign accept = start && !busy;

   svcm_table #(.ENTRIES(ENTRIES)) u_table (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (AW'(req_entry_index)),
      .wr_speed  (req_table_speed),
      .wr_offset (req_table_offset),
      .rd_addr   (addr_in),
      .rd_speed  (rd_speed),
      .rd_offset (rd_offset)
   );

   svcm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   svcm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mul_prod),
      .den   (den_ff),
      .quo   (div_q),
      .done  (div_done)
   );

   // search compare and neighbor differences
   assign hit      = $signed(req_ff) < $signed(rd_speed);
   assign first    = addr_ff == '0;
   assign last     = addr_ff == AW'(ENTRIES - 1);
   assign r_full   = {req_ff[SPD_W-1], req_ff} - {prev_spd_ff[SPD_W-1], prev_spd_ff};
   assign den_full = {rd_speed[SPD_W-1], rd_speed} - {prev_spd_ff[SPD_W-1], prev_spd_ff};
   assign d_full   = {rd_offset[OFS_W-1], rd_offset} - {prev_ofs_ff[OFS_W-1], prev_ofs_ff};
   assign d_abs    = d_full[OFS_W] ? -d_full : d_full;

   // operand magnitudes for the shared multiplier
   assign omag  = ofs_ff[OFS_W-1] ? -ofs_ff : ofs_ff;
   assign gmag  = gain_ff[GAIN_W-1] ? -gain_ff : gain_ff;
   assign mul_a = (state_ff == ST_INTERP_GO) ? dmag_ff : omag;
   assign mul_b = (state_ff == ST_INTERP_GO) ? r_ff : gmag;

   assign q_signed   = dneg_ff ? -div_q : div_q;
   assign interp_sum = {o0_ff[OFS_W-1], o0_ff} + q_signed;

   // truncate toward zero, saturate, recenter
   assign smag      = mul_prod[MUL_P_W-1:GAIN_FRAC];
   assign sat       = smag > (MUL_P_W-GAIN_FRAC)'(LIMIT_US);
   assign cmag      = sat ? MAG_W'(LIMIT_US) : smag[MAG_W-1:0];
   assign sneg      = gain_ff[GAIN_W-1] ^ ofs_ff[OFS_W-1];
   assign scaled    = sneg ? -{{(SUM_W-MAG_W){1'b0}}, cmag} : {{(SUM_W-MAG_W){1'b0}}, cmag};
   assign pulse_sum = SUM_W'(CENTER_US) + scaled;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_SPEED) begin
               state_in = ST_SEARCH;
            end else if (accept && req_kind == KIND_DIRECT) begin
               state_in = ST_SCALE_GO;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               state_in = first ? ST_SCALE_GO : ST_INTERP_GO;
            end else if (last) begin
               state_in = ST_SCALE_GO;
            end
         end
         ST_INTERP_GO:  state_in = ST_INTERP_MUL;
         ST_INTERP_MUL: if (mul_done) state_in = ST_INTERP_DIV;
         ST_INTERP_DIV: if (div_done) state_in = ST_SCALE_GO;
         ST_SCALE_GO:   state_in = ST_SCALE_MUL;
         ST_SCALE_MUL:  if (mul_done) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy          = 1'b1;
      tbl_we        = 1'b0;
      ld_req        = 1'b0;
      ld_prev       = 1'b0;
      ld_interp     = 1'b0;
      ld_ofs        = 1'b0;
      ld_rsp        = 1'b0;
      mul_start     = 1'b0;
      div_start     = 1'b0;
      rsp_strobe_in = 1'b0;
      addr_in       = addr_ff;
      ofs_in        = ofs_ff;
      unique case (state_ff)
         ST_IDLE: begin
            busy    = 1'b0;
            addr_in = '0;
            if (accept) begin
               tbl_we = (req_kind == KIND_LOAD)
                      && ({1'b0, req_entry_index} < (IDX_W+1)'(ENTRIES));
               ld_req = req_kind == KIND_SPEED;
               if (req_kind == KIND_DIRECT) begin
                  ld_ofs = 1'b1;
                  ofs_in = req_direct_offset;
               end
            end
         end
         ST_SEARCH: begin
            if (hit && !first) begin
               ld_interp = 1'b1;
            end else if (hit || last) begin
               ld_ofs = 1'b1;
               ofs_in = rd_offset;
            end else begin
               ld_prev = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_INTERP_GO:  mul_start = 1'b1;
         ST_INTERP_MUL: div_start = mul_done;
         ST_INTERP_DIV: begin
            if (div_done) begin
               ld_ofs = 1'b1;
               ofs_in = interp_sum[OFS_W-1:0];
            end
         end
         ST_SCALE_GO:   mul_start = 1'b1;
         ST_SCALE_MUL: begin
            ld_rsp        = mul_done;
            rsp_strobe_in = mul_done;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gain_ff       <= GAIN_RESET;
         ofs_ff        <= '0;
         addr_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         if (ld_ofs) begin
            ofs_ff <= ofs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_req) begin
         req_ff <= req_speed_request;
      end
      if (ld_prev) begin
         prev_spd_ff <= rd_speed;
         prev_ofs_ff <= rd_offset;
      end
      if (ld_interp) begin
         o0_ff   <= prev_ofs_ff;
         dneg_ff <= d_full[OFS_W];
         dmag_ff <= d_abs[MUL_A_W-1:0];
         r_ff    <= r_full[MUL_B_W-1:0];
         den_ff  <= den_full[DIV_D_W-1:0];
      end
      if (ld_rsp) begin
         rsp_pulse_ff   <= pulse_sum[PULSE_W-1:0];
         rsp_clamped_ff <= sat;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_pulse_us = rsp_pulse_ff;
   assign rsp_clamped  = rsp_clamped_ff;

   a_pulse_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && OUT_FITS |->
         (rsp_pulse_us >= PULSE_W'(CENTER_US - LIMIT_US))
         && (rsp_pulse_us <= PULSE_W'(CENTER_US + LIMIT_US)))
      else $error("pulse width outside the limit band");

   a_clamp_at_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_clamped && OUT_FITS |->
         (rsp_pulse_us == PULSE_W'(CENTER_US + LIMIT_US))
         || (rsp_pulse_us == PULSE_W'(CENTER_US - LIMIT_US)))
      else $error("clamped result not at the limit");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("busy dropped without a result word");

   a_result_word_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == KIND_SPEED || req_kind == KIND_DIRECT) |=> busy)
      else $error("result-producing word did not raise busy");

endmodule

`default_nettype wire
